@@ rtl/gbl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbl_pkg
// Shared types, codes and helpers of the group-of-pictures bit budget ledger.
// ----------------------------------------------------------------------------
package gbl_pkg;

	localparam int MAX_GROUPS_DEF = 1024;
	localparam int BITS_WIDTH     = 48;

	// serial multiply-divide unit widths
	localparam int MD_AW = 48;
	localparam int MD_BW = 40;
	localparam int MD_PW = MD_AW + MD_BW;
	localparam int MD_DW = 48;
	localparam int MD_CW = 7;

	localparam logic [BITS_WIDTH-1:0] BITS_MAX    = '1;
	localparam logic [47:0]           HUNDRED_Q16 = 48'd6553600;
	localparam logic [47:0]           DEV_MAX     = 48'h7FFF_FFFF_FFFF;
	localparam logic [47:0]           DEV_LIM     = 48'h7FFF_FFFF_FFFF + 48'd6553600;

	localparam logic [2:0] OP_LOAD   = 3'd0;
	localparam logic [2:0] OP_SEAL   = 3'd1;
	localparam logic [2:0] OP_LAUNCH = 3'd2;
	localparam logic [2:0] OP_COMMIT = 3'd3;
	localparam logic [2:0] OP_REPORT = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_ORDER = 2'd1;
	localparam logic [1:0] ST_VALUE = 2'd2;
	localparam logic [1:0] ST_PHASE = 2'd3;

	localparam logic [1:0] REG_BIT_RATE = 2'd0;
	localparam logic [1:0] REG_RATE_NUM = 2'd1;
	localparam logic [1:0] REG_RATE_DEN = 2'd2;

	typedef struct packed {
		logic [2:0]  operation;
		logic [9:0]  group_index;
		logic [15:0] group_frames;
		logic [23:0] group_scale;
		logic [47:0] coded_bits;
	} gbl_in_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [31:0]        multiplier;
		logic [47:0]        reserved_budget_out;
		logic signed [47:0] deviation;
	} gbl_out_t;

	typedef struct packed {
		logic [MD_AW-1:0] a;
		logic [MD_BW-1:0] b;
		logic [MD_DW-1:0] d;
	} gbl_md_req_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_MD1,
		S_MD2,
		S_DONE
	} gbl_state_t;

	typedef enum logic [1:0] {
		MD_IDLE,
		MD_MUL,
		MD_DIV
	} gbl_md_state_t;

	function automatic logic [BITS_WIDTH-1:0] sat_add(input logic [BITS_WIDTH-1:0] a,
		input logic [BITS_WIDTH-1:0] b);
		logic [BITS_WIDTH:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[BITS_WIDTH] ? BITS_MAX : s[BITS_WIDTH-1:0];
	endfunction

endpackage

@@ rtl/gbl_muldiv.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbl_muldiv
// Serial floor(a * b / d): shift-add multiply, one bit a cycle, then
// restoring division, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module gbl_muldiv (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       go,
	input  gbl_pkg::gbl_md_req_t       req,
	output logic                       done,
	output logic [gbl_pkg::MD_PW-1:0]  quo
);

	localparam logic [gbl_pkg::MD_CW-1:0] MUL_LAST = gbl_pkg::MD_CW'(gbl_pkg::MD_BW - 1);
	localparam logic [gbl_pkg::MD_CW-1:0] DIV_LAST = gbl_pkg::MD_CW'(gbl_pkg::MD_PW - 1);

	gbl_pkg::gbl_md_state_t st_q, st_nx;
	logic [gbl_pkg::MD_CW-1:0] cnt_q;
	logic                      done_q;
	logic [gbl_pkg::MD_AW-1:0] a_q;
	logic [gbl_pkg::MD_BW-1:0] b_q;
	logic [gbl_pkg::MD_DW-1:0] d_q;
	logic [gbl_pkg::MD_PW-1:0] acc_q;
	logic [gbl_pkg::MD_DW-1:0] rem_q;
	logic [gbl_pkg::MD_DW:0]   trial;
	logic                      ge;

	assign trial = {rem_q, acc_q[gbl_pkg::MD_PW-1]};
	assign ge    = trial >= {1'b0, d_q};

	always_comb begin
		st_nx = st_q;
		case (st_q)
			gbl_pkg::MD_IDLE: begin
				if (go) st_nx = gbl_pkg::MD_MUL;
			end
			gbl_pkg::MD_MUL: begin
				if (cnt_q == '0) st_nx = gbl_pkg::MD_DIV;
			end
			gbl_pkg::MD_DIV: begin
				if (cnt_q == '0) st_nx = gbl_pkg::MD_IDLE;
			end
			default: st_nx = gbl_pkg::MD_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= gbl_pkg::MD_IDLE;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			st_q   <= st_nx;
			done_q <= (st_q == gbl_pkg::MD_DIV) && (cnt_q == '0);
			case (st_q)
				gbl_pkg::MD_IDLE: cnt_q <= MUL_LAST;
				gbl_pkg::MD_MUL:  cnt_q <= (cnt_q == '0) ? DIV_LAST : cnt_q - 1'b1;
				gbl_pkg::MD_DIV:  cnt_q <= cnt_q - 1'b1;
				default:          cnt_q <= '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			gbl_pkg::MD_IDLE: begin
				if (go) begin
					a_q   <= req.a;
					b_q   <= req.b;
					d_q   <= req.d;
					acc_q <= '0;
					rem_q <= '0;
				end
			end
			gbl_pkg::MD_MUL: begin
				acc_q <= {acc_q[gbl_pkg::MD_PW-2:0], 1'b0}
					+ (b_q[gbl_pkg::MD_BW-1] ? {{gbl_pkg::MD_BW{1'b0}}, a_q} : '0);
				b_q   <= {b_q[gbl_pkg::MD_BW-2:0], 1'b0};
			end
			gbl_pkg::MD_DIV: begin
				acc_q <= {acc_q[gbl_pkg::MD_PW-2:0], ge};
				rem_q <= ge ? gbl_pkg::MD_DW'(trial - {1'b0, d_q}) : trial[gbl_pkg::MD_DW-1:0];
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign quo  = acc_q;

endmodule

@@ rtl/gop_bit_budget_ledger_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gop_bit_budget_ledger_core
// Two-pass bit budget ledger for groups of pictures: load, seal, launch,
// commit and report items against two on-chip stores.
// ----------------------------------------------------------------------------
//  channel   | handshake                     | payload
//  ----------+-------------------------------+-------------------------
//  item in   | start, busy                   | item_in  (gbl_in_t)
//  result    | done (one-cycle strobe)       | result   (gbl_out_t)
//  config    | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// Load, seal and report run the shared serial unit once (40 multiply plus 88
// divide steps); launch runs it twice, or once when the budget is exhausted.
// Commit and rejected items skip the unit. One item is in flight at a time.
// Reset clears all control state; the two stores hold garbage until written.
// done is high for one cycle and cannot be stalled; result holds to the next item.
// ----------------------------------------------------------------------------
module gop_bit_budget_ledger_core #(
	parameter int MAX_GROUPS = gbl_pkg::MAX_GROUPS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  gbl_pkg::gbl_in_t  item_in,
	output logic              done,
	output gbl_pkg::gbl_out_t result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int AW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
	localparam int CW = $clog2(MAX_GROUPS + 1);
	localparam int XW = (CW > 10) ? CW : 10;
	localparam int BW = gbl_pkg::BITS_WIDTH;

	gbl_pkg::gbl_state_t state_q, state_nx;
	gbl_pkg::gbl_in_t    item_q;
	gbl_pkg::gbl_out_t   result_q;

	logic [31:0]   br_q;
	logic [15:0]   rn_q, rd_q;
	logic [CW-1:0] gc_q, nl_q, nc_q;
	logic [31:0]   ft_q;
	logic [BW-1:0] remn_q, tgt_q, spent_q, held_q;
	logic          sealed_q;

	logic [BW-1:0] nom_mem [MAX_GROUPS];
	logic [BW-1:0] res_mem [MAX_GROUPS];
	logic [BW-1:0] nom_rd_q, res_rd_q;

	logic                          md_go, md_done;
	gbl_pkg::gbl_md_req_t          md_req;
	logic [gbl_pkg::MD_PW-1:0]     md_quo;

	logic [1:0]    eval_status;
	logic [BW-1:0] used;
	logic          exhausted;
	logic [BW-1:0] q_sat;
	logic [31:0]   mult_v;
	logic [47:0]   rate_prod;
	logic [39:0]   frame_scale;
	logic [32:0]   ft_sum;
	logic          cfg_wr;

	assign used        = gbl_pkg::sat_add(spent_q, held_q);
	assign exhausted   = used >= tgt_q;
	assign rate_prod   = br_q * rd_q;
	assign frame_scale = item_q.group_frames * item_q.group_scale;
	assign q_sat       = (|md_quo[gbl_pkg::MD_PW-1:BW]) ? gbl_pkg::BITS_MAX : md_quo[BW-1:0];
	assign ft_sum      = {1'b0, ft_q} + 33'(item_q.group_frames);
	assign cfg_wr      = psel && penable && pwrite && pready;

	always_comb begin
		mult_v = (|md_quo[gbl_pkg::MD_PW-1:32]) ? 32'hFFFF_FFFF : md_quo[31:0];
		if (mult_v == '0) mult_v = 32'd1;
	end

	always_comb begin
		eval_status = gbl_pkg::ST_OK;
		case (item_q.operation)
			gbl_pkg::OP_LOAD: begin
				if (sealed_q || gc_q >= CW'(MAX_GROUPS)) eval_status = gbl_pkg::ST_PHASE;
				else if (item_q.group_frames == '0 || item_q.group_scale == '0 || rn_q == '0)
					eval_status = gbl_pkg::ST_VALUE;
			end
			gbl_pkg::OP_SEAL: begin
				if (sealed_q || gc_q == '0) eval_status = gbl_pkg::ST_PHASE;
				else if (rn_q == '0) eval_status = gbl_pkg::ST_VALUE;
			end
			gbl_pkg::OP_LAUNCH: begin
				if (!sealed_q) eval_status = gbl_pkg::ST_PHASE;
				else if (XW'(item_q.group_index) != XW'(nl_q) || nl_q >= gc_q)
					eval_status = gbl_pkg::ST_ORDER;
			end
			gbl_pkg::OP_COMMIT: begin
				if (XW'(item_q.group_index) != XW'(nc_q) || nc_q >= nl_q)
					eval_status = gbl_pkg::ST_ORDER;
			end
			gbl_pkg::OP_REPORT: begin
				if (!sealed_q || tgt_q == '0) eval_status = gbl_pkg::ST_PHASE;
			end
			default: eval_status = gbl_pkg::ST_VALUE;
		endcase
	end

	always_comb begin
		md_go  = 1'b0;
		md_req = '0;
		if (state_q == gbl_pkg::S_EVAL && eval_status == gbl_pkg::ST_OK) begin
			case (item_q.operation)
				gbl_pkg::OP_LOAD: begin
					md_go  = 1'b1;
					md_req = '{a: rate_prod, b: frame_scale, d: {16'd0, rn_q, 16'd0}};
				end
				gbl_pkg::OP_SEAL: begin
					md_go  = 1'b1;
					md_req = '{a: rate_prod, b: {8'd0, ft_q}, d: {32'd0, rn_q}};
				end
				gbl_pkg::OP_LAUNCH: begin
					md_go = 1'b1;
					if (exhausted) md_req = '{a: nom_rd_q, b: 40'd1, d: 48'd65536};
					else md_req = '{a: tgt_q - used, b: 40'd65536,
						d: (remn_q == '0) ? 48'd1 : remn_q};
				end
				gbl_pkg::OP_REPORT: begin
					md_go  = 1'b1;
					md_req = '{a: spent_q, b: 40'(gbl_pkg::HUNDRED_Q16), d: tgt_q};
				end
				default: ;
			endcase
		end else if (state_q == gbl_pkg::S_MD1 && md_done
			&& item_q.operation == gbl_pkg::OP_LAUNCH) begin
			md_go  = 1'b1;
			md_req = '{a: nom_rd_q, b: {8'd0, mult_v}, d: 48'd65536};
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			gbl_pkg::S_IDLE: begin
				if (start) state_nx = gbl_pkg::S_EVAL;
			end
			gbl_pkg::S_EVAL: begin
				if (eval_status != gbl_pkg::ST_OK || item_q.operation == gbl_pkg::OP_COMMIT)
					state_nx = gbl_pkg::S_DONE;
				else if (item_q.operation == gbl_pkg::OP_LAUNCH && exhausted)
					state_nx = gbl_pkg::S_MD2;
				else state_nx = gbl_pkg::S_MD1;
			end
			gbl_pkg::S_MD1: begin
				if (md_done) state_nx = (item_q.operation == gbl_pkg::OP_LAUNCH)
					? gbl_pkg::S_MD2 : gbl_pkg::S_DONE;
			end
			gbl_pkg::S_MD2: begin
				if (md_done) state_nx = gbl_pkg::S_DONE;
			end
			gbl_pkg::S_DONE: state_nx = gbl_pkg::S_IDLE;
			default:         state_nx = gbl_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		busy   = state_q != gbl_pkg::S_IDLE;
		done   = state_q == gbl_pkg::S_DONE;
		result = result_q;
		pready = 1'b1;
		case (paddr[3:2])
			gbl_pkg::REG_BIT_RATE: prdata = br_q;
			gbl_pkg::REG_RATE_NUM: prdata = {16'd0, rn_q};
			gbl_pkg::REG_RATE_DEN: prdata = {16'd0, rd_q};
			default:               prdata = '0;
		endcase
	end

	gbl_muldiv u_md (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (md_go),
		.req    (md_req),
		.done   (md_done),
		.quo    (md_quo)
	);

	// stores: one write port each, registered read every cycle at the next launch / commit pointer
	always_ff @(posedge clk) begin
		if (state_q == gbl_pkg::S_MD1 && md_done && item_q.operation == gbl_pkg::OP_LOAD
			&& q_sat != '0)
			nom_mem[gc_q[AW-1:0]] <= q_sat;
		if (state_q == gbl_pkg::S_MD2 && md_done)
			res_mem[nl_q[AW-1:0]] <= q_sat;
		nom_rd_q <= nom_mem[nl_q[AW-1:0]];
		res_rd_q <= res_mem[nc_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (state_q == gbl_pkg::S_IDLE && start) item_q <= item_in;
		case (state_q)
			gbl_pkg::S_EVAL: begin
				result_q        <= '0;
				result_q.status <= eval_status;
				if (eval_status == gbl_pkg::ST_OK) begin
					if (item_q.operation == gbl_pkg::OP_COMMIT)
						result_q.reserved_budget_out <= res_rd_q;
					if (item_q.operation == gbl_pkg::OP_LAUNCH && exhausted)
						result_q.multiplier <= 32'd1;
				end
			end
			gbl_pkg::S_MD1: begin
				if (md_done) begin
					case (item_q.operation)
						gbl_pkg::OP_LOAD: begin
							if (q_sat == '0) result_q.status <= gbl_pkg::ST_VALUE;
							else result_q.reserved_budget_out <= q_sat;
						end
						gbl_pkg::OP_SEAL: begin
							if (q_sat == '0) result_q.status <= gbl_pkg::ST_VALUE;
						end
						gbl_pkg::OP_LAUNCH: result_q.multiplier <= mult_v;
						gbl_pkg::OP_REPORT: begin
							if ((|md_quo[gbl_pkg::MD_PW-1:48]) || md_quo[47:0] > gbl_pkg::DEV_LIM)
								result_q.deviation <= gbl_pkg::DEV_MAX;
							else result_q.deviation <= md_quo[47:0] - gbl_pkg::HUNDRED_Q16;
						end
						default: ;
					endcase
				end
			end
			gbl_pkg::S_MD2: begin
				if (md_done) result_q.reserved_budget_out <= q_sat;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= gbl_pkg::S_IDLE;
			br_q     <= 32'd40000000;
			rn_q     <= 16'd24000;
			rd_q     <= 16'd1001;
			gc_q     <= '0;
			nl_q     <= '0;
			nc_q     <= '0;
			ft_q     <= '0;
			remn_q   <= '0;
			tgt_q    <= '0;
			spent_q  <= '0;
			held_q   <= '0;
			sealed_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_wr) begin
				case (paddr[3:2])
					gbl_pkg::REG_BIT_RATE: br_q <= pwdata;
					gbl_pkg::REG_RATE_NUM: rn_q <= pwdata[15:0];
					gbl_pkg::REG_RATE_DEN: rd_q <= pwdata[15:0];
					default: ;
				endcase
			end
			case (state_q)
				gbl_pkg::S_EVAL: begin
					if (eval_status == gbl_pkg::ST_OK && item_q.operation == gbl_pkg::OP_COMMIT) begin
						held_q  <= (held_q > res_rd_q) ? held_q - res_rd_q : '0;
						spent_q <= gbl_pkg::sat_add(spent_q, item_q.coded_bits);
						nc_q    <= nc_q + 1'b1;
					end
				end
				gbl_pkg::S_MD1: begin
					if (md_done && q_sat != '0) begin
						if (item_q.operation == gbl_pkg::OP_LOAD) begin
							gc_q   <= gc_q + 1'b1;
							ft_q   <= ft_sum[32] ? 32'hFFFF_FFFF : ft_sum[31:0];
							remn_q <= gbl_pkg::sat_add(remn_q, q_sat);
						end else if (item_q.operation == gbl_pkg::OP_SEAL) begin
							tgt_q    <= q_sat;
							sealed_q <= 1'b1;
						end
					end
				end
				gbl_pkg::S_MD2: begin
					if (md_done) begin
						held_q <= gbl_pkg::sat_add(held_q, q_sat);
						remn_q <= (remn_q > nom_rd_q) ? remn_q - nom_rd_q : '0;
						nl_q   <= nl_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_commit_behind_launch: assert property (@(posedge clk) disable iff (!arst_n)
		nc_q <= nl_q) else $error("commit pointer ahead of launch pointer");
	a_launch_behind_load: assert property (@(posedge clk) disable iff (!arst_n)
		nl_q <= gc_q) else $error("launch pointer ahead of group count");
	a_busy_ends_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(done)) else $error("item ended without a result");
	a_sealed_has_target: assert property (@(posedge clk) disable iff (!arst_n)
		sealed_q |-> tgt_q != '0) else $error("sealed with zero target");
`endif

endmodule
